// ----- hdl/smd_pkg.sv -----
package smd_pkg;

  // header layout
  localparam int unsigned HDR_LEN    = 20;
  localparam int unsigned TID_START  = 8;
  localparam logic [7:0]  LEAD_MASK  = 8'hC0;
  localparam logic [31:0] COOKIE     = 32'h2112A442;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

  // attribute walker phase codes
  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_PAY = 2'd1;
  localparam logic [1:0] PH_PAD = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TID     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdict codes, in check order except that overrun is checked before a truncated header
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_LEAD_BITS = 3'd2;
  localparam logic [2:0] ST_LEN       = 3'd3;
  localparam logic [2:0] ST_COOKIE    = 3'd4;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd5;
  localparam logic [2:0] ST_OVERRUN   = 3'd6;

  // result queue, depth must be a power of two
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [15:0] tlv_type;
    logic [15:0] attr_length;
    logic [15:0] byte_offset;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic        last_result;
  } result_t;

  // up to two results per byte
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ----- hdl/smd_parser.sv -----
module smd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output smd_pkg::push_t       push_o
);

  logic [16:0] cnt_q, cnt_d;
  logic [15:0] type_q, type_d;
  logic [15:0] blen_q, blen_d;
  logic [31:0] cookie_q, cookie_d;
  logic        lead_q, lead_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] ahs_q, ahs_d;
  logic [15:0] pos_q, pos_d;

  logic [15:0] pos_inc;
  logic [1:0]  pad;
  logic        data_vld;
  logic [1:0]  data_kind;
  logic [15:0] data_at, data_al, data_off;
  logic [2:0]  status;
  smd_pkg::result_t data_res, verdict_res;

  assign pos_inc = pos_q + 16'd1;

  always_comb begin
    cnt_d     = (cnt_q < smd_pkg::COUNT_MAX) ? cnt_q + 17'd1 : cnt_q;
    type_d    = type_q;
    blen_d    = blen_q;
    cookie_d  = cookie_q;
    lead_d    = lead_q;
    phase_d   = phase_q;
    ahs_d     = ahs_q;
    pos_d     = pos_q;
    pad       = 2'd0;
    data_vld  = 1'b0;
    data_kind = smd_pkg::KIND_TID;
    data_at   = '0;
    data_al   = '0;
    data_off  = '0;
    if (cnt_q < 17'(smd_pkg::HDR_LEN)) begin
      if (cnt_q == 17'd0) begin
        lead_d = |(byte_i & smd_pkg::LEAD_MASK);
      end
      if (cnt_q < 17'd2) begin
        type_d = {type_q[7:0], byte_i};
      end else if (cnt_q < 17'd4) begin
        blen_d = {blen_q[7:0], byte_i};
      end else if (cnt_q < 17'(smd_pkg::TID_START)) begin
        cookie_d = {cookie_q[23:0], byte_i};
      end else begin
        data_vld = 1'b1;
        data_off = cnt_q[15:0] - 16'(smd_pkg::TID_START);
      end
    end else begin
      unique case (phase_q)
        smd_pkg::PH_PAY: begin
          data_vld  = 1'b1;
          data_kind = smd_pkg::KIND_PAYLOAD;
          data_at   = ahs_q[31:16];
          data_al   = ahs_q[15:0];
          data_off  = pos_q;
          pos_d     = pos_inc;
          if (pos_inc == ahs_q[15:0]) begin
            pad     = 2'd0 - ahs_q[1:0];
            phase_d = (pad == 2'd0) ? smd_pkg::PH_HDR : smd_pkg::PH_PAD;
            pos_d   = {14'd0, pad};
          end
        end
        smd_pkg::PH_PAD: begin
          pos_d = pos_q - 16'd1;
          if (pos_d == 16'd0) begin
            phase_d = smd_pkg::PH_HDR;
          end
        end
        default: begin
          ahs_d = {ahs_q[23:0], byte_i};
          pos_d = pos_inc;
          if (pos_inc >= 16'd4) begin
            pos_d = '0;
            if (ahs_d[15:0] != 16'd0) begin
              phase_d = smd_pkg::PH_PAY;
            end
          end
        end
      endcase
    end
  end

  // verdict looks at the state after this byte
  always_comb begin
    if (cnt_d < 17'(smd_pkg::HDR_LEN)) begin
      status = smd_pkg::ST_SHORT;
    end else if (lead_d) begin
      status = smd_pkg::ST_LEAD_BITS;
    end else if (cnt_d != 17'(smd_pkg::HDR_LEN) + {1'b0, blen_d}) begin
      status = smd_pkg::ST_LEN;
    end else if (cookie_d != smd_pkg::COOKIE) begin
      status = smd_pkg::ST_COOKIE;
    end else if (phase_d == smd_pkg::PH_PAY) begin
      status = smd_pkg::ST_OVERRUN;
    end else if (phase_d == smd_pkg::PH_HDR && pos_d != 16'd0) begin
      status = smd_pkg::ST_TRUNC_HDR;
    end else begin
      status = smd_pkg::ST_OK;
    end
  end

  always_comb begin
    data_res.kind        = data_kind;
    data_res.msg_type    = type_d;
    data_res.tlv_type    = data_at;
    data_res.attr_length = data_al;
    data_res.byte_offset = data_off;
    data_res.out_byte    = byte_i;
    data_res.status      = smd_pkg::ST_OK;
    data_res.last_result = ~last_i;

    verdict_res.kind        = smd_pkg::KIND_VERDICT;
    verdict_res.msg_type    = type_d;
    verdict_res.tlv_type    = '0;
    verdict_res.attr_length = '0;
    verdict_res.byte_offset = '0;
    verdict_res.out_byte    = '0;
    verdict_res.status      = status;
    verdict_res.last_result = 1'b1;

    if (data_vld) begin
      push_o.res0 = data_res;
      push_o.res1 = verdict_res;
      push_o.num  = valid_i ? (last_i ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      push_o.res0 = verdict_res;
      push_o.res1 = verdict_res;
      push_o.num  = (valid_i && last_i) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      type_q   <= '0;
      blen_q   <= '0;
      cookie_q <= '0;
      lead_q   <= 1'b0;
      phase_q  <= smd_pkg::PH_HDR;
      ahs_q    <= '0;
      pos_q    <= '0;
    end else if (valid_i) begin
      if (last_i) begin
        cnt_q    <= '0;
        type_q   <= '0;
        blen_q   <= '0;
        cookie_q <= '0;
        lead_q   <= 1'b0;
        phase_q  <= smd_pkg::PH_HDR;
        ahs_q    <= '0;
        pos_q    <= '0;
      end else begin
        cnt_q    <= cnt_d;
        type_q   <= type_d;
        blen_q   <= blen_d;
        cookie_q <= cookie_d;
        lead_q   <= lead_d;
        phase_q  <= phase_d;
        ahs_q    <= ahs_d;
        pos_q    <= pos_d;
      end
    end
  end

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |=> cnt_q == 17'd0 && phase_q == smd_pkg::PH_HDR)
    else $error("state not cleared after final byte");

  a_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == smd_pkg::PH_PAD |-> pos_q != 16'd0 && pos_q <= 16'd3)
    else $error("padding count out of range");

  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == smd_pkg::PH_HDR |-> pos_q < 16'd4)
    else $error("attribute header position out of range");

endmodule

// ----- hdl/smd_result_fifo.sv -----
module smd_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smd_pkg::push_t    push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output smd_pkg::result_t  res_o
);

  smd_pkg::result_t mem_q [smd_pkg::FIFO_DEPTH];

  logic [smd_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [smd_pkg::FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [smd_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                           pop;

  // room for a worst-case push of two
  assign room_o     = count_q <= smd_pkg::FIFO_CNT_W'(smd_pkg::FIFO_DEPTH - 2);
  assign valid_o    = count_q != '0;
  assign pop        = valid_o && ready_i;
  assign res_o      = mem_q[rd_ptr_q];
  assign wr_ptr_nxt = wr_ptr_q + smd_pkg::FIFO_PTR_W'(1);

  // pointers wrap naturally at the power-of-two depth
  always_comb begin
    wr_ptr_d = wr_ptr_q + smd_pkg::FIFO_PTR_W'(push_i.num);
    rd_ptr_d = rd_ptr_q + smd_pkg::FIFO_PTR_W'(pop);
    count_d  = count_q + smd_pkg::FIFO_CNT_W'(push_i.num) - smd_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smd_pkg::FIFO_CNT_W'(smd_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(res_o))
    else $error("output transaction changed while stalled");

endmodule

// ----- hdl/stun_message_deframer.sv -----
// channel | handshake                         | payload
// --------+-----------------------------------+----------------------------------------
// input   | in_valid_i / in_ready_o           | data_byte_i, last_byte_i
// output  | out_valid_o / out_ready_i         | kind_o, msg_type_o, tlv_type_o,
//         |                                   | attr_length_o, byte_offset_o,
//         |                                   | out_byte_o, status_o, last_result_o
//
// one byte per cycle sustained while the output is ready: a byte that yields one result (or none) is taken every cycle
// a final byte that also carries a data result yields two results, drained one per cycle while the output is ready
// results of an accepted byte pass through the input register, then the result queue, to the outputs
// asynchronous active-low reset clears the parser state and empties the result queue
// output stalls back up through the four-entry result queue into the input register
module stun_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] msg_type_o,
  output logic [15:0] tlv_type_o,
  output logic [15:0] attr_length_o,
  output logic [15:0] byte_offset_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_result_o
);

  // input register, holds one byte until the queue has room for its results
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic             room;
  logic             take;
  smd_pkg::push_t   push;
  smd_pkg::result_t res;

  // byte in the input register is parsed once the queue can absorb two results
  assign take       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset, it is only looked at while valid
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // header capture, attribute walker and verdict
  smd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(take),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  // result queue decouples the two-result case from the output handshake
  smd_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (res)
  );

  assign kind_o        = res.kind;
  assign msg_type_o    = res.msg_type;
  assign tlv_type_o    = res.tlv_type;
  assign attr_length_o = res.attr_length;
  assign byte_offset_o = res.byte_offset;
  assign out_byte_o    = res.out_byte;
  assign status_o      = res.status;
  assign last_result_o = res.last_result;

endmodule

// ----- sim/stun_deframe_checker.sv -----
`timescale 1ns / 100ps

module stun_deframe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,

  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] msg_type_i,
  input  logic [15:0] tlv_type_i,
  input  logic [15:0] attr_length_i,
  input  logic [15:0] byte_offset_i,
  input  logic [7:0]  out_byte_i,
  input  logic [2:0]  status_i,
  input  logic        last_result_i,

  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // parser state, mirrored from the block's behavior
  logic [16:0] rx_count;
  logic [15:0] hdr_type;
  logic [15:0] hdr_body_len;
  logic [31:0] hdr_cookie;
  logic        lead_bad;
  logic [1:0]  walk_phase;
  logic [31:0] tlv_hdr;
  logic [15:0] walk_pos;

  smd_pkg::result_t expected_results[$];
  smd_pkg::result_t oldest;

  task automatic clear_parser();
    rx_count     = '0;
    hdr_type     = '0;
    hdr_body_len = '0;
    hdr_cookie   = '0;
    lead_bad     = 1'b0;
    walk_phase   = smd_pkg::PH_HDR;
    tlv_hdr      = '0;
    walk_pos     = '0;
  endtask

  function automatic smd_pkg::result_t form_result(input logic [1:0] kind,
                                                   input logic [15:0] a_type,
                                                   input logic [15:0] a_len,
                                                   input logic [15:0] offset,
                                                   input logic [7:0] data,
                                                   input logic [2:0] verdict);
    smd_pkg::result_t r;
    r.kind        = kind;
    r.msg_type    = hdr_type;
    r.tlv_type    = a_type;
    r.attr_length = a_len;
    r.byte_offset = offset;
    r.out_byte    = data;
    r.status      = verdict;
    r.last_result = 1'b0;
    return r;
  endfunction

  // one accepted byte: update the parser and queue the results it causes
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    logic [16:0]      idx;
    logic [1:0]       pad;
    logic [2:0]       verdict;
    smd_pkg::result_t made[2];
    int               n;
    idx = rx_count;
    n = 0;
    if (rx_count != smd_pkg::COUNT_MAX) rx_count = rx_count + 1'b1;

    if (idx < smd_pkg::HDR_LEN) begin
      if (idx == 0) lead_bad = (b & smd_pkg::LEAD_MASK) != 0;
      if (idx < 2) hdr_type = {hdr_type[7:0], b};
      else if (idx < 4) hdr_body_len = {hdr_body_len[7:0], b};
      else if (idx < smd_pkg::TID_START) hdr_cookie = {hdr_cookie[23:0], b};
      else begin
        made[n] = form_result(smd_pkg::KIND_TID, '0, '0,
                              idx[15:0] - 16'(smd_pkg::TID_START), b, smd_pkg::ST_OK);
        n++;
      end
    end else if (walk_phase == smd_pkg::PH_PAY) begin
      made[n] = form_result(smd_pkg::KIND_PAYLOAD, tlv_hdr[31:16], tlv_hdr[15:0], walk_pos, b,
                            smd_pkg::ST_OK);
      n++;
      walk_pos = walk_pos + 1'b1;
      if (walk_pos == tlv_hdr[15:0]) begin
        pad = 2'd0 - tlv_hdr[1:0];
        walk_phase = (pad == 0) ? smd_pkg::PH_HDR : smd_pkg::PH_PAD;
        walk_pos = {14'd0, pad};
      end
    end else if (walk_phase == smd_pkg::PH_PAD) begin
      walk_pos = walk_pos - 1'b1;
      if (walk_pos == 0) walk_phase = smd_pkg::PH_HDR;
    end else begin
      tlv_hdr = {tlv_hdr[23:0], b};
      walk_pos = walk_pos + 1'b1;
      if (walk_pos >= 4) begin
        walk_pos = '0;
        if (tlv_hdr[15:0] != 0) walk_phase = smd_pkg::PH_PAY;
      end
    end

    if (lst) begin
      // first failing check wins
      if (rx_count < smd_pkg::HDR_LEN) verdict = smd_pkg::ST_SHORT;
      else if (lead_bad) verdict = smd_pkg::ST_LEAD_BITS;
      else if (rx_count != smd_pkg::HDR_LEN + hdr_body_len) verdict = smd_pkg::ST_LEN;
      else if (hdr_cookie != smd_pkg::COOKIE) verdict = smd_pkg::ST_COOKIE;
      else if (walk_phase == smd_pkg::PH_PAY) verdict = smd_pkg::ST_OVERRUN;
      else if (walk_phase == smd_pkg::PH_HDR && walk_pos != 0) verdict = smd_pkg::ST_TRUNC_HDR;
      else verdict = smd_pkg::ST_OK;
      made[n] = form_result(smd_pkg::KIND_VERDICT, '0, '0, '0, '0, verdict);
      n++;
      clear_parser();
    end

    for (int i = 0; i < n; i++) begin
      made[i].last_result = (i == n - 1);
      expected_results.push_back(made[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) deframe_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d, byte 0x%0h", kind_i, out_byte_i);
          fail_count_o++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 16'(oldest.kind), 16'(kind_i));
          check_field("msg_type", oldest.msg_type, msg_type_i);
          check_field("tlv_type", oldest.tlv_type, tlv_type_i);
          check_field("attr_length", oldest.attr_length, attr_length_i);
          check_field("byte_offset", oldest.byte_offset, byte_offset_i);
          check_field("out_byte", 16'(oldest.out_byte), 16'(out_byte_i));
          check_field("status", 16'(oldest.status), 16'(status_i));
          check_field("last_result", 16'(oldest.last_result), 16'(last_result_i));
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [15:0] msg_type_o;
  logic [15:0] tlv_type_o;
  logic [15:0] attr_length_o;
  logic [15:0] byte_offset_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  status_o;
  logic        last_result_o;

  int unsigned fail_count;
  int unsigned results_pending;

  // datagram under construction: attribute area first, then the full frame
  logic [7:0]  body[$];
  logic [7:0]  frame[$];
  logic [1:0]  last_pad;
  int unsigned bytes_sent;
  bit          held;

  stun_message_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .msg_type_o    (msg_type_o),
    .tlv_type_o    (tlv_type_o),
    .attr_length_o (attr_length_o),
    .byte_offset_o (byte_offset_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

  stun_deframe_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .msg_type_i    (msg_type_o),
    .tlv_type_i    (tlv_type_o),
    .attr_length_i (attr_length_o),
    .byte_offset_i (byte_offset_o),
    .out_byte_i    (out_byte_o),
    .status_i      (status_o),
    .last_result_i (last_result_o),
    .fail_count_o  (fail_count),
    .pending_o     (results_pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full attribute: 4-byte header, payload, padding up to a 4-byte boundary
  task automatic add_attr(input logic [15:0] atype, input logic [15:0] alen);
    body.push_back(atype[15:8]);
    body.push_back(atype[7:0]);
    body.push_back(alen[15:8]);
    body.push_back(alen[7:0]);
    repeat (alen) body.push_back(8'($urandom_range(0, 255)));
    last_pad = 2'd0 - alen[1:0];
    repeat (last_pad) body.push_back(8'($urandom_range(0, 255)));
  endtask

  // one byte per transaction, last flag on the final byte
  task automatic send_frame(input bit gaps);
    int gap;
    foreach (frame[i]) begin
      in_valid_i  <= 1'b1;
      data_byte_i <= frame[i];
      last_byte_i <= (i == frame.size() - 1);
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      bytes_sent++;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // header in front of the body; len_skew breaks the length field, cut truncates
  task automatic deliver(input logic [15:0] mtype, input int len_skew,
                         input logic [31:0] cookie, input int cut, input bit gaps);
    logic [15:0] blen;
    blen = 16'(body.size() + len_skew);
    frame = {};
    frame.push_back(mtype[15:8]);
    frame.push_back(mtype[7:0]);
    frame.push_back(blen[15:8]);
    frame.push_back(blen[7:0]);
    for (int i = 3; i >= 0; i--) frame.push_back(cookie[8*i +: 8]);
    repeat (smd_pkg::HDR_LEN - smd_pkg::TID_START) frame.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) frame.push_back(body[i]);
    if (cut > 0) while (frame.size() > cut) void'(frame.pop_back());
    send_frame(gaps);
    body = {};
  endtask

  // mostly well-formed messages with random content, the rest broken or noise
  task automatic random_frame();
    int          pick;
    int          r;
    int          skew;
    int          cut;
    bit          gaps;
    logic [15:0] mtype;
    logic [15:0] alen;
    logic [31:0] cookie;
    logic [31:0] flip;
    pick   = $urandom_range(0, 99);
    gaps   = $urandom_range(0, 3) != 0;
    mtype  = 16'($urandom_range(0, 16'h3FFF));
    cookie = smd_pkg::COOKIE;
    skew   = 0;
    cut    = 0;
    body   = {};
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 99);
      alen = 16'((r < 35) ? $urandom_range(0, 3) :
                 (r < 85) ? $urandom_range(4, 16) : $urandom_range(17, 48));
      add_attr(16'($urandom), alen);
    end

    if (pick < 55) begin
      // sometimes stop inside the trailing padding
      if (last_pad > 0 && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, last_pad)) void'(body.pop_back());
    end else if (pick < 61) begin
      cut = $urandom_range(1, smd_pkg::HDR_LEN - 1);
    end else if (pick < 67) begin
      mtype[15:14] = 2'($urandom_range(1, 3));
    end else if (pick < 73) begin
      skew = $urandom_range(1, 65535);
    end else if (pick < 79) begin
      flip = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
      if (flip == 0) flip = 32'd1;
      cookie = smd_pkg::COOKIE ^ flip;
    end else if (pick < 86) begin
      // attribute header cut short
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      // declared payload runs past the end
      alen = 16'($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 65535));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(alen[15:8]);
      body.push_back(alen[7:0]);
      repeat ($urandom_range(0, (alen > 40) ? 40 : alen - 1))
        body.push_back(8'($urandom_range(0, 255)));
    end

    if (pick >= 93) begin
      frame = {};
      repeat ($urandom_range(1, 64)) frame.push_back(8'($urandom_range(0, 255)));
      send_frame(gaps);
    end else begin
      deliver(mtype, skew, cookie, cut, gaps);
    end
  endtask

  // receiver: ready in runs with random stalls, plus one long hold-off while
  // the sender keeps going so the result queue and input register fill up
  initial begin
    int run_len;
    int stall;
    @(posedge rst_ni);
    forever begin
      if (!held && bytes_sent >= 300) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      run_len = $urandom_range(1, 24);
      out_ready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned random_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // header only, widest legal message type
    deliver(16'h3FFF, 0, smd_pkg::COOKIE, 0, 1'b1);
    // zero-length attribute followed by a padded one
    add_attr(16'h0000, 16'h0000);
    add_attr(16'hFFFF, 16'h0005);
    deliver(16'h0000, 0, smd_pkg::COOKIE, 0, 1'b1);
    // aligned attribute, then one that ends inside its padding
    add_attr(16'h8028, 16'h0004);
    add_attr(16'h0006, 16'h0001);
    repeat (2) void'(body.pop_back());
    deliver(16'h0101, 0, smd_pkg::COOKIE, 0, 1'b0);
    // ends right after an attribute header with nonzero length
    add_attr(16'h0020, 16'h0007);
    repeat (8) void'(body.pop_back());
    deliver(16'h0111, 0, smd_pkg::COOKIE, 0, 1'b1);
    // ends inside a payload
    add_attr(16'h0008, 16'h000C);
    repeat (5) void'(body.pop_back());
    deliver(16'h0001, 0, smd_pkg::COOKIE, 0, 1'b1);
    // ends with half an attribute header
    add_attr(16'h0024, 16'h0000);
    repeat (2) void'(body.pop_back());
    deliver(16'h0001, 0, smd_pkg::COOKIE, 0, 1'b0);
    // short datagrams: one byte, one short of a header, short with bad lead bits
    deliver(16'h0000, 0, smd_pkg::COOKIE, 1, 1'b1);
    deliver(16'h0001, 0, smd_pkg::COOKIE, smd_pkg::HDR_LEN - 1, 1'b1);
    deliver(16'hFFFF, 0, smd_pkg::COOKIE, 5, 1'b0);
    // header checks one at a time
    deliver(16'hC000, 0, smd_pkg::COOKIE, 0, 1'b1);
    add_attr(16'h0006, 16'h0003);
    deliver(16'h0101, 4, smd_pkg::COOKIE, 0, 1'b1);
    deliver(16'h0101, 0, ~smd_pkg::COOKIE, 0, 1'b1);

    random_start = bytes_sent;
    while (bytes_sent - random_start < 600) random_frame();

    // drain: let the checker see the last transaction, then wait for results
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (results_pending == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
